FILE: hdl/i2cspm_pkg.sv
// ----------------------------------------------------------------------------
// i2cspm_pkg
// Shared types and constants for the I2C slave pointer memory block.
// ----------------------------------------------------------------------------
package i2cspm_pkg;

	// Width of the pointer and of the remainder unit operands.
	localparam int PTR_W = 9;

	// Framed bus event codes.
	typedef enum logic [2:0] {
		CMD_ADDR_WRITE = 3'd0,
		CMD_DATA_BYTE  = 3'd1,
		CMD_STOP       = 3'd2,
		CMD_ADDR_READ  = 3'd3,
		CMD_READ_ACK   = 3'd4,
		CMD_READ_NACK  = 3'd5
	} cmd_t;

	// Register indexes on the configuration port.
	localparam logic REG_OWN_ADDRESS = 1'b0;
	localparam logic REG_BUFFER_SIZE = 1'b1;

	// Register reset values.
	localparam logic [6:0]       OWN_ADDRESS_RST = 7'd56;
	localparam logic [PTR_W-1:0] BUFFER_SIZE_RST = 9'd256;

	// ASCII digit bounds for the LED rule.
	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_NINE = 8'h39;

	// Request to the remainder unit.
	typedef struct packed {
		logic             start;
		logic [PTR_W-1:0] dividend;
		logic [PTR_W-1:0] divisor;
	} mod_req_t;

	// Response from the remainder unit.
	typedef struct packed {
		logic             done;
		logic [PTR_W-1:0] remainder;
	} mod_rsp_t;

endpackage

FILE: hdl/i2cspm_mod.sv
// ----------------------------------------------------------------------------
// i2cspm_mod
// Restoring remainder unit: one dividend bit per cycle, done pulses for one
// cycle with the remainder valid.
// ----------------------------------------------------------------------------
module i2cspm_mod (
	input  logic                clk,
	input  logic                arst_n,
	input  i2cspm_pkg::mod_req_t req,
	output i2cspm_pkg::mod_rsp_t rsp
);
	import i2cspm_pkg::*;

	localparam int CNT_W = $clog2(PTR_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] step_q;
	logic [PTR_W-1:0] dvd_q;
	logic [PTR_W-1:0] dvs_q;
	logic [PTR_W-1:0] rem_q;
	logic [PTR_W:0]   trial;
	logic [PTR_W-1:0] rem_next;

	// Shift in the next dividend bit and subtract the divisor when it fits.
	always_comb begin
		trial = {rem_q, dvd_q[PTR_W-1]};
		if (trial >= {1'b0, dvs_q}) begin
			rem_next = PTR_W'(trial - {1'b0, dvs_q});
		end else begin
			rem_next = PTR_W'(trial);
		end
	end

	// Step counter and completion flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == CNT_W'(PTR_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and partial remainder registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[PTR_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign rsp.done      = done_q;
	assign rsp.remainder = rem_q;

endmodule

FILE: hdl/i2c_slave_pointer_memory.sv
// ----------------------------------------------------------------------------
// i2c_slave_pointer_memory
// Slave side of an I2C bus with a pointer-addressed byte memory behind it.
//
//   Channel   Handshake            Payload
//   input     in_valid/in_ready    cmd, bus_address, data_byte
//   output    out_valid/out_ready  read_data, ack, led_on
//   config    APB write/read       own_address (0x0), buffer_size (0x4)
//
// An address write, an unmatched address read, a stop, a nack or an unused
// event goes from ST_IDLE straight to ST_DONE. A pointer byte passes through
// ST_DIV, and a stored or read byte through ST_DIV and ST_MEM; the remainder
// unit reduces the pointer in ST_DIV, one bit per cycle.
// After reset all MEM_DEPTH bytes are swept to zero, one byte a cycle, and no
// beat is taken meanwhile; configuration writes are taken at any time.
// One event is in flight at a time; a result waits in the output register
// while the next event is taken, and a finished event stalls until it is free.
// ----------------------------------------------------------------------------
module i2c_slave_pointer_memory #(
	parameter int MEM_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// Event input
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [6:0]  bus_address,
	input  logic [7:0]  data_byte,
	// Result output
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_data,
	output logic        ack,
	output logic        led_on,
	// Configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import i2cspm_pkg::*;

	localparam int AW = $clog2(MEM_DEPTH);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_MEM,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_SETPTR,
		OP_WRITE,
		OP_READ
	} op_t;

	state_t           state_q;
	op_t              op_q;
	logic [AW-1:0]    clr_q;
	logic [6:0]       own_addr_q;
	logic [PTR_W-1:0] buf_size_q;
	logic [PTR_W-1:0] eff_size;
	logic [PTR_W-1:0] ptr_q;
	logic [PTR_W-1:0] idx_q;
	logic [PTR_W:0]   idx_inc;
	logic [PTR_W-1:0] ptr_adv;
	logic             awaiting_q;
	logic             led_q;
	logic             res_ack_q;
	logic [7:0]       data_q;
	logic             start_q;
	logic [PTR_W-1:0] dividend_q;
	logic             out_valid_q;
	logic [7:0]       read_data_q;
	logic             ack_q;
	logic             led_on_q;
	logic             addr_match;
	logic             mem_we;
	logic [AW-1:0]    mem_addr;
	logic [7:0]       mem_wdata;
	logic [7:0]       mem_rdata_q;
	logic [7:0]       mem [MEM_DEPTH];
	mod_req_t         mod_req;
	mod_rsp_t         mod_rsp;

	// Configuration registers; the port never stalls.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q <= OWN_ADDRESS_RST;
			buf_size_q <= BUFFER_SIZE_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_OWN_ADDRESS: own_addr_q <= pwdata[6:0];
				REG_BUFFER_SIZE: buf_size_q <= pwdata[PTR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_OWN_ADDRESS: prdata = {25'd0, own_addr_q};
			REG_BUFFER_SIZE: prdata = {23'd0, buf_size_q};
			default:         prdata = '0;
		endcase
	end

	// Effective buffer size, limited to 1..MEM_DEPTH.
	always_comb begin
		if (buf_size_q == '0) begin
			eff_size = PTR_W'(1);
		end else if (32'(buf_size_q) > MEM_DEPTH) begin
			eff_size = PTR_W'(MEM_DEPTH);
		end else begin
			eff_size = buf_size_q;
		end
	end

	// Pointer advance with wrap; the reduced index is already below the size.
	assign idx_inc = {1'b0, idx_q} + 1'b1;
	assign ptr_adv = (idx_inc == {1'b0, eff_size}) ? '0 : idx_inc[PTR_W-1:0];

	assign addr_match = (bus_address == own_addr_q);

	// Shared remainder unit.
	assign mod_req.start    = start_q;
	assign mod_req.dividend = dividend_q;
	assign mod_req.divisor  = eff_size;

	i2cspm_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	// Sequencer: state, pointer, flags and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			op_q        <= OP_NONE;
			clr_q       <= '0;
			ptr_q       <= '0;
			idx_q       <= '0;
			awaiting_q  <= 1'b1;
			led_q       <= 1'b0;
			res_ack_q   <= 1'b0;
			start_q     <= 1'b0;
			dividend_q  <= '0;
			out_valid_q <= 1'b0;
			read_data_q <= 8'd0;
			ack_q       <= 1'b0;
			led_on_q    <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(MEM_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						op_q      <= OP_NONE;
						res_ack_q <= 1'b0;
						state_q   <= ST_DONE;
						case (cmd)
							CMD_ADDR_WRITE: begin
								if (addr_match) begin
									awaiting_q <= 1'b1;
									res_ack_q  <= 1'b1;
								end
							end
							CMD_DATA_BYTE: begin
								res_ack_q <= 1'b1;
								start_q   <= 1'b1;
								state_q   <= ST_DIV;
								if (awaiting_q) begin
									op_q       <= OP_SETPTR;
									dividend_q <= {1'b0, data_byte};
								end else begin
									op_q       <= OP_WRITE;
									dividend_q <= ptr_q;
								end
							end
							CMD_STOP, CMD_READ_NACK: begin
								res_ack_q <= 1'b1;
							end
							CMD_ADDR_READ: begin
								if (addr_match) begin
									res_ack_q  <= 1'b1;
									op_q       <= OP_READ;
									start_q    <= 1'b1;
									dividend_q <= ptr_q;
									state_q    <= ST_DIV;
								end
							end
							CMD_READ_ACK: begin
								res_ack_q  <= 1'b1;
								op_q       <= OP_READ;
								start_q    <= 1'b1;
								dividend_q <= ptr_q;
								state_q    <= ST_DIV;
							end
							default: ;
						endcase
					end
				end
				ST_DIV: begin
					if (mod_rsp.done) begin
						if (op_q == OP_SETPTR) begin
							ptr_q      <= mod_rsp.remainder;
							awaiting_q <= 1'b0;
							state_q    <= ST_DONE;
						end else begin
							idx_q   <= mod_rsp.remainder;
							state_q <= ST_MEM;
						end
					end
				end
				ST_MEM: begin
					ptr_q <= ptr_adv;
					if (op_q == OP_WRITE && idx_q == '0) begin
						led_q <= (data_q >= ASCII_ZERO) && (data_q <= ASCII_NINE);
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						read_data_q <= (op_q == OP_READ) ? mem_rdata_q : 8'd0;
						ack_q       <= res_ack_q;
						led_on_q    <= led_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Event data byte, kept for the memory write.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= data_byte;
		end
	end

	// Byte memory: the reset sweep and event writes share one write port.
	assign mem_we    = (state_q == ST_CLEAR) || (state_q == ST_MEM && op_q == OP_WRITE);
	assign mem_addr  = (state_q == ST_CLEAR) ? clr_q : AW'(idx_q);
	assign mem_wdata = (state_q == ST_CLEAR) ? 8'd0 : data_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		mem_rdata_q <= mem[mem_addr];
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign ack       = ack_q;
	assign led_on    = led_on_q;

	// Only one event is worked on at a time.
	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("event taken while another is in flight");

	// The remainder unit finishes only while the sequencer waits for it.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		mod_rsp.done |-> state_q == ST_DIV)
		else $error("remainder done outside the divide step");

	// A memory access always uses an index below the effective size.
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MEM |-> idx_q < eff_size)
		else $error("memory index not reduced");

	// The LED moves only after a write at location zero.
	a_led_src: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(led_q) |-> $past(state_q == ST_MEM && op_q == OP_WRITE && idx_q == '0))
		else $error("LED changed without a location zero write");

endmodule
